// ===== rtl/hpdt_pkg.sv =====
// Package for the hashed pair dedupe table.
// Holds sizes, codes, shared structs and the FNV-1a fold. Depends on nothing.
package hpdt_pkg;

   localparam int BUCKET_COUNT = 1024;
   localparam int WAY_COUNT = 4;
   localparam int MAX_ID_BYTES = 128;
   localparam int ENTRY_COUNT = BUCKET_COUNT * WAY_COUNT;
   localparam int BUCKET_W = $clog2(BUCKET_COUNT);
   localparam int WAY_W = $clog2(WAY_COUNT);
   localparam int ENTRY_W = BUCKET_W + WAY_W;
   localparam int IDX_W = $clog2(MAX_ID_BYTES);
   localparam int LEN_W = IDX_W + 1;
   localparam int CNT_W = 13;
   localparam int OVF_W = 32;
   localparam int INFO_W = 1 + 2 * LEN_W;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME_LOW = 64'd435;
   localparam logic [7:0] SEP_BYTE = 8'hff;

   localparam logic PART_TRADE = 1'b0;
   localparam logic PART_ORDER = 1'b1;

   typedef enum logic [1:0] {
      OP_QUERY,
      OP_INSERT,
      OP_CLEAR,
      OP_UNUSED
   } op_type;

   typedef enum logic [2:0] {
      ST_ABSENT,
      ST_PRESENT,
      ST_INSERTED,
      ST_FULL,
      ST_BAD_KEY,
      ST_CLEARED
   } status_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_PROC,
      FR_FINISH
   } front_state_type;

   typedef enum logic [3:0] {
      BK_INIT,
      BK_IDLE,
      BK_INFO_RD,
      BK_INFO_CHK,
      BK_CMP_RD,
      BK_CMP_CHK,
      BK_MATCH,
      BK_NEXT,
      BK_DECIDE,
      BK_COPY_RD,
      BK_COPY_WR,
      BK_INFO_WR,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      op_type op;
      logic [LEN_W-1:0] trade_len;
      logic [LEN_W-1:0] order_len;
      logic [BUCKET_W-1:0] bucket;
   } cmd_type;

   typedef struct packed {
      logic we;
      logic side;
      logic [IDX_W-1:0] addr;
      logic [7:0] data;
   } kbuf_wr_type;

   typedef struct packed {
      logic init_busy;
      logic cmd_done;
   } back_status_type;

   function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x * FNV_PRIME_LOW);
   endfunction

   function automatic logic len_ok(input logic [LEN_W-1:0] len);
      return (len != '0) && (len <= LEN_W'(MAX_ID_BYTES));
   endfunction

endpackage

// ===== rtl/hashed_pair_dedupe_table.sv =====
// Duplicate filter for (trade id, order id) pairs with an FNV-1a hashed table.
// Request channel req_*: at most one byte per request; trade bytes, then order
// bytes, req_last ends the command and req_op of that request selects query,
// insert or clear-order. Response channel rsp_*: one response per command.
// The front part takes a new request only after it has processed the last
// one, and folds the separator before the first order byte. A finished
// command waits in a queue for the back part; the front takes bytes of the
// next command once the back part has responded. A query or insert probes
// the 4 ways of its bucket and compares stored bytes, and an insert then copies
// the key bytes into a free way; a clear scans all 4096 entries and compares
// order bytes. The table memories are single-port. After reset, a pass over
// all 4096 entries clears the valid bits and req_ready stays low. A stalled
// response is held in the output register; the back part waits for it to be
// taken before it loads the next one.
// Depends on hpdt_pkg, hpdt_front, hpdt_cmd_fifo and hpdt_back.
module hashed_pair_dedupe_table
   import hpdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic        req_part,
   input  logic        req_has_byte,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [12:0] rsp_cleared_count,
   output logic [31:0] rsp_overflow_total
);

   back_status_type back_status;
   kbuf_wr_type kbuf_wr;
   logic push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_data, pop_data;

   hpdt_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_part(req_part), .req_has_byte(req_has_byte),
      .req_key_byte(req_key_byte), .req_last(req_last),
      .back_status(back_status), .kbuf_wr(kbuf_wr),
      .cmd_valid(push_valid), .cmd_ready(push_ready), .cmd_data(push_data)
   );

   hpdt_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   hpdt_back u_back (
      .clock(clock), .reset(reset), .kbuf_wr(kbuf_wr),
      .cmd_valid(pop_valid), .cmd_ready(pop_ready), .cmd_data(pop_data),
      .back_status(back_status),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_cleared_count(rsp_cleared_count),
      .rsp_overflow_total(rsp_overflow_total)
   );

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_CLEARED))
      else $error("Response status out of range.");

   a_cleared_only_on_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cleared_count != '0) |-> (rsp_status == ST_CLEARED))
      else $error("Cleared count set on a response that is not a clear.");

   a_no_request_in_init: assert property (@(posedge clock) disable iff (reset)
      back_status.init_busy |-> !req_ready)
      else $error("Request accepted during the clearing pass.");

endmodule

// ===== rtl/hpdt_cmd_fifo.sv =====
// Two-entry command queue between the front and back parts.
// Depends on hpdt_pkg for the command struct.
module hpdt_cmd_fifo
   import hpdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/hpdt_front.sv =====
// Front part: takes byte requests, fills the key buffers and folds the hash.
// Depends on hpdt_pkg; feeds hpdt_cmd_fifo and the key buffers in hpdt_back.
module hpdt_front
   import hpdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_op,
   input  logic            req_part,
   input  logic            req_has_byte,
   input  logic [7:0]      req_key_byte,
   input  logic            req_last,
   input  back_status_type back_status,
   output kbuf_wr_type     kbuf_wr,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output cmd_type         cmd_data
);

   front_state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic part_ff, has_byte_ff, last_ff;
   logic [7:0] byte_ff;
   logic [LEN_W-1:0] tlen_ff, tlen_in, olen_ff, olen_in;
   logic [63:0] hash_ff, hash_in;
   logic sep_ff, sep_in;
   logic busy_ff, busy_in;
   logic take;

   assign req_ready = (state_ff == FR_IDLE) && !busy_ff && !back_status.init_busy;
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      tlen_in = tlen_ff;
      olen_in = olen_ff;
      hash_in = hash_ff;
      sep_in = sep_ff;
      busy_in = busy_ff;
      kbuf_wr = '0;
      cmd_valid = 1'b0;
      cmd_data.op = op_type'(op_ff);
      cmd_data.trade_len = tlen_ff;
      cmd_data.order_len = olen_ff;
      cmd_data.bucket = hash_ff[BUCKET_W-1:0];
      if (back_status.cmd_done) begin
         busy_in = 1'b0;
      end
      case (state_ff)
         FR_IDLE: begin
            if (take) begin
               state_in = FR_PROC;
            end
         end
         FR_PROC: begin
            if (has_byte_ff && part_ff == PART_ORDER && !sep_ff) begin
               hash_in = fnv_fold(hash_ff, SEP_BYTE);
               sep_in = 1'b1;
            end else begin
               if (has_byte_ff && part_ff == PART_TRADE) begin
                  if (sep_ff) begin
                     tlen_in = LEN_W'(MAX_ID_BYTES + 1);
                  end else begin
                     kbuf_wr.we = !tlen_ff[LEN_W-1];
                     kbuf_wr.side = PART_TRADE;
                     kbuf_wr.addr = tlen_ff[IDX_W-1:0];
                     kbuf_wr.data = byte_ff;
                     if (tlen_ff <= LEN_W'(MAX_ID_BYTES)) begin
                        tlen_in = tlen_ff + 1'b1;
                     end
                     hash_in = fnv_fold(hash_ff, byte_ff);
                  end
               end else if (has_byte_ff) begin
                  kbuf_wr.we = !olen_ff[LEN_W-1];
                  kbuf_wr.side = PART_ORDER;
                  kbuf_wr.addr = olen_ff[IDX_W-1:0];
                  kbuf_wr.data = byte_ff;
                  if (olen_ff <= LEN_W'(MAX_ID_BYTES)) begin
                     olen_in = olen_ff + 1'b1;
                  end
                  hash_in = fnv_fold(hash_ff, byte_ff);
               end
               state_in = last_ff ? FR_FINISH : FR_IDLE;
            end
         end
         FR_FINISH: begin
            if (!sep_ff) begin
               hash_in = fnv_fold(hash_ff, SEP_BYTE);
               sep_in = 1'b1;
            end else begin
               cmd_valid = 1'b1;
               if (cmd_ready) begin
                  tlen_in = '0;
                  olen_in = '0;
                  hash_in = FNV_BASIS;
                  sep_in = 1'b0;
                  busy_in = 1'b1;
                  state_in = FR_IDLE;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         tlen_ff <= '0;
         olen_ff <= '0;
         hash_ff <= FNV_BASIS;
         sep_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tlen_ff <= tlen_in;
         olen_ff <= olen_in;
         hash_ff <= hash_in;
         sep_ff <= sep_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff <= req_op;
         part_ff <= req_part;
         has_byte_ff <= req_has_byte;
         byte_ff <= req_key_byte;
         last_ff <= req_last;
      end
   end

endmodule

// ===== rtl/hpdt_back.sv =====
// Back part: probes buckets, compares stored keys, inserts and clears entries.
// Depends on hpdt_pkg; holds the key buffers and all table memories.
module hpdt_back
   import hpdt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  kbuf_wr_type      kbuf_wr,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cmd_type          cmd_data,
   output back_status_type  back_status,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_cleared_count,
   output logic [OVF_W-1:0] rsp_overflow_total
);

   logic [INFO_W-1:0] info_mem [ENTRY_COUNT];
   logic [7:0] tbyte_mem [ENTRY_COUNT * MAX_ID_BYTES];
   logic [7:0] obyte_mem [ENTRY_COUNT * MAX_ID_BYTES];
   logic [7:0] tkey_mem [MAX_ID_BYTES];
   logic [7:0] okey_mem [MAX_ID_BYTES];

   back_state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [LEN_W-1:0] tlen_ff, tlen_in, olen_ff, olen_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic side_ff, side_in;
   logic found_ff, found_in;
   logic free_ok_ff, free_ok_in;
   logic [ENTRY_W-1:0] free_entry_ff, free_entry_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OVF_W-1:0] ovf_ff, ovf_in;
   status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff;
   logic [CNT_W-1:0] rsp_cleared_ff;
   logic [OVF_W-1:0] rsp_ovf_ff;
   logic rsp_load;

   logic [INFO_W-1:0] info_rd_ff;
   logic [7:0] tb_rd_ff, ob_rd_ff, tk_rd_ff, ok_rd_ff;
   logic info_we, tb_we, ob_we;
   logic [INFO_W-1:0] info_wdata;
   logic [ENTRY_W+IDX_W-1:0] store_addr;
   logic info_valid;
   logic [LEN_W-1:0] info_tlen, info_olen, side_len;
   logic is_clear;

   assign store_addr = {entry_ff, idx_ff[IDX_W-1:0]};
   assign info_valid = info_rd_ff[INFO_W-1];
   assign info_tlen = info_rd_ff[2*LEN_W-1:LEN_W];
   assign info_olen = info_rd_ff[LEN_W-1:0];
   assign side_len = (side_ff == PART_TRADE) ? tlen_ff : olen_ff;
   assign is_clear = (op_ff == OP_CLEAR);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cleared_count = rsp_cleared_ff;
   assign rsp_overflow_total = rsp_ovf_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      tlen_in = tlen_ff;
      olen_in = olen_ff;
      entry_in = entry_ff;
      idx_in = idx_ff;
      side_in = side_ff;
      found_in = found_ff;
      free_ok_in = free_ok_ff;
      free_entry_in = free_entry_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      status_in = status_ff;
      cmd_ready = 1'b0;
      info_we = 1'b0;
      info_wdata = '0;
      tb_we = 1'b0;
      ob_we = 1'b0;
      rsp_load = 1'b0;
      back_status.init_busy = (state_ff == BK_INIT);
      back_status.cmd_done = 1'b0;
      case (state_ff)
         BK_INIT: begin
            info_we = 1'b1;
            entry_in = entry_ff + 1'b1;
            if (entry_ff == ENTRY_W'(ENTRY_COUNT - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in = cmd_data.op;
               tlen_in = cmd_data.trade_len;
               olen_in = cmd_data.order_len;
               found_in = 1'b0;
               free_ok_in = 1'b0;
               cnt_in = '0;
               state_in = BK_INFO_RD;
               if (cmd_data.op == OP_CLEAR) begin
                  entry_in = '0;
                  if (!len_ok(cmd_data.order_len)) begin
                     status_in = ST_BAD_KEY;
                     state_in = BK_RESULT;
                  end
               end else begin
                  entry_in = {cmd_data.bucket, {WAY_W{1'b0}}};
                  if (cmd_data.op == OP_UNUSED || !len_ok(cmd_data.trade_len)
                      || !len_ok(cmd_data.order_len)) begin
                     status_in = ST_BAD_KEY;
                     state_in = BK_RESULT;
                  end
               end
            end
         end
         BK_INFO_RD: begin
            state_in = BK_INFO_CHK;
         end
         BK_INFO_CHK: begin
            if (!info_valid && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_entry_in = entry_ff;
            end
            if (info_valid && info_olen == olen_ff && (is_clear || info_tlen == tlen_ff)) begin
               idx_in = '0;
               side_in = PART_ORDER;
               state_in = BK_CMP_RD;
            end else begin
               state_in = BK_NEXT;
            end
         end
         BK_CMP_RD: begin
            state_in = BK_CMP_CHK;
         end
         BK_CMP_CHK: begin
            if ((side_ff == PART_TRADE) ? (tb_rd_ff != tk_rd_ff) : (ob_rd_ff != ok_rd_ff)) begin
               state_in = BK_NEXT;
            end else if (idx_ff + 1'b1 == side_len) begin
               if (side_ff == PART_ORDER && !is_clear) begin
                  side_in = PART_TRADE;
                  idx_in = '0;
                  state_in = BK_CMP_RD;
               end else begin
                  state_in = BK_MATCH;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = BK_CMP_RD;
            end
         end
         BK_MATCH: begin
            if (is_clear) begin
               info_we = 1'b1;
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = BK_NEXT;
            end else begin
               found_in = 1'b1;
               state_in = BK_DECIDE;
            end
         end
         BK_NEXT: begin
            if (is_clear) begin
               if (entry_ff == ENTRY_W'(ENTRY_COUNT - 1)) begin
                  status_in = ST_CLEARED;
                  state_in = BK_RESULT;
               end else begin
                  entry_in = entry_ff + 1'b1;
                  state_in = BK_INFO_RD;
               end
            end else if (entry_ff[WAY_W-1:0] == WAY_W'(WAY_COUNT - 1)) begin
               state_in = BK_DECIDE;
            end else begin
               entry_in = entry_ff + 1'b1;
               state_in = BK_INFO_RD;
            end
         end
         BK_DECIDE: begin
            state_in = BK_RESULT;
            if (found_ff) begin
               status_in = ST_PRESENT;
            end else if (op_ff == OP_QUERY) begin
               status_in = ST_ABSENT;
            end else if (free_ok_ff) begin
               entry_in = free_entry_ff;
               idx_in = '0;
               side_in = PART_TRADE;
               state_in = BK_COPY_RD;
            end else begin
               status_in = ST_FULL;
               if (ovf_ff != '1) begin
                  ovf_in = ovf_ff + 1'b1;
               end
            end
         end
         BK_COPY_RD: begin
            state_in = BK_COPY_WR;
         end
         BK_COPY_WR: begin
            tb_we = (side_ff == PART_TRADE);
            ob_we = (side_ff == PART_ORDER);
            if (idx_ff + 1'b1 == side_len) begin
               idx_in = '0;
               if (side_ff == PART_TRADE) begin
                  side_in = PART_ORDER;
                  state_in = BK_COPY_RD;
               end else begin
                  state_in = BK_INFO_WR;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = BK_COPY_RD;
            end
         end
         BK_INFO_WR: begin
            info_we = 1'b1;
            info_wdata = {1'b1, tlen_ff, olen_ff};
            status_in = ST_INSERTED;
            state_in = BK_RESULT;
         end
         BK_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               back_status.cmd_done = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_INIT;
         entry_ff <= '0;
         ovf_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         entry_ff <= entry_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      tlen_ff <= tlen_in;
      olen_ff <= olen_in;
      idx_ff <= idx_in;
      side_ff <= side_in;
      found_ff <= found_in;
      free_ok_ff <= free_ok_in;
      free_entry_ff <= free_entry_in;
      cnt_ff <= cnt_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_cleared_ff <= cnt_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         info_mem[entry_ff] <= info_wdata;
      end
      info_rd_ff <= info_mem[entry_ff];
      if (tb_we) begin
         tbyte_mem[store_addr] <= tk_rd_ff;
      end
      tb_rd_ff <= tbyte_mem[store_addr];
      if (ob_we) begin
         obyte_mem[store_addr] <= ok_rd_ff;
      end
      ob_rd_ff <= obyte_mem[store_addr];
      if (kbuf_wr.we && kbuf_wr.side == PART_TRADE) begin
         tkey_mem[kbuf_wr.addr] <= kbuf_wr.data;
      end
      if (kbuf_wr.we && kbuf_wr.side == PART_ORDER) begin
         okey_mem[kbuf_wr.addr] <= kbuf_wr.data;
      end
      tk_rd_ff <= tkey_mem[idx_ff[IDX_W-1:0]];
      ok_rd_ff <= okey_mem[idx_ff[IDX_W-1:0]];
   end

endmodule

// ===== tb/tb_hashed_pair_dedupe_table.sv =====
// Self-checking testbench for hashed_pair_dedupe_table.
// Streams byte requests, tracks the expected table contents and compares every response.
// Depends on hpdt_pkg and the hashed_pair_dedupe_table RTL.
`timescale 1ns / 100ps

module tb_hashed_pair_dedupe_table;
   import hpdt_pkg::*;

   typedef logic [7:0] key_q[$];

   typedef struct {
      status_type status;
      logic [12:0] cleared;
      logic [31:0] overflows;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = '0;
   logic req_part = 1'b0;
   logic req_has_byte = 1'b0;
   logic [7:0] req_key_byte = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [12:0] rsp_cleared_count;
   logic [31:0] rsp_overflow_total;

   // Shadow copy of the table and of the command being assembled.
   bit slot_valid[ENTRY_COUNT];
   key_q slot_trade[ENTRY_COUNT];
   key_q slot_order[ENTRY_COUNT];
   key_q cur_trade;
   key_q cur_order;
   int cur_trade_len;
   int cur_order_len;
   logic [63:0] cur_hash;
   bit cur_sep_done;
   logic [31:0] overflow_total;

   answer_type pending_answers[$];
   int errors = 0;
   int items_sent = 0;
   bit no_idle = 1'b0;
   bit hold_rsp = 1'b0;

   key_q pool_trade[40];
   key_q pool_order[40];

   hashed_pair_dedupe_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_part(req_part), .req_has_byte(req_has_byte),
      .req_key_byte(req_key_byte), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_cleared_count(rsp_cleared_count),
      .rsp_overflow_total(rsp_overflow_total)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
      return (h ^ {56'd0, b}) * 64'd1099511628211;
   endfunction

   function automatic logic [BUCKET_W-1:0] bucket_of(key_q trade, key_q order);
      logic [63:0] h;
      h = 64'd14695981039346656037;
      foreach (trade[i]) h = fnv_step(h, trade[i]);
      h = fnv_step(h, 8'hff);
      foreach (order[i]) h = fnv_step(h, order[i]);
      return h[BUCKET_W-1:0];
   endfunction

   function automatic bit same_key(key_q a, key_q b);
      if (a.size() != b.size()) return 1'b0;
      foreach (a[i]) if (a[i] !== b[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit id_len_ok(int len);
      return len >= 1 && len <= MAX_ID_BYTES;
   endfunction

   function automatic void restart_key();
      cur_trade.delete();
      cur_order.delete();
      cur_trade_len = 0;
      cur_order_len = 0;
      cur_hash = 64'd14695981039346656037;
      cur_sep_done = 1'b0;
   endfunction

   function automatic void fold_separator();
      if (!cur_sep_done) begin
         cur_hash = fnv_step(cur_hash, 8'hff);
         cur_sep_done = 1'b1;
      end
   endfunction

   // Applies one accepted request to the shadow table; queues a response on last.
   function automatic void apply_request(op_type op, logic part, logic has_byte,
                                         logic [7:0] kb, logic last);
      answer_type ans;
      int base;
      bit found;
      ans.status = ST_BAD_KEY;
      ans.cleared = '0;
      if (has_byte) begin
         if (part == PART_TRADE) begin
            if (cur_sep_done) begin
               cur_trade_len = MAX_ID_BYTES + 1;
            end else begin
               if (cur_trade_len < MAX_ID_BYTES) cur_trade.push_back(kb);
               if (cur_trade_len <= MAX_ID_BYTES) cur_trade_len++;
               cur_hash = fnv_step(cur_hash, kb);
            end
         end else begin
            fold_separator();
            if (cur_order_len < MAX_ID_BYTES) cur_order.push_back(kb);
            if (cur_order_len <= MAX_ID_BYTES) cur_order_len++;
            cur_hash = fnv_step(cur_hash, kb);
         end
      end
      if (!last) return;
      fold_separator();
      if (op == OP_QUERY || op == OP_INSERT) begin
         if (id_len_ok(cur_trade_len) && id_len_ok(cur_order_len)) begin
            base = int'(cur_hash[BUCKET_W-1:0]) * WAY_COUNT;
            found = 1'b0;
            for (int w = 0; w < WAY_COUNT; w++)
               if (slot_valid[base + w] && same_key(slot_order[base + w], cur_order)
                   && same_key(slot_trade[base + w], cur_trade)) found = 1'b1;
            if (found) begin
               ans.status = ST_PRESENT;
            end else if (op == OP_QUERY) begin
               ans.status = ST_ABSENT;
            end else begin
               ans.status = ST_FULL;
               for (int w = 0; w < WAY_COUNT; w++) begin
                  if (ans.status == ST_FULL && !slot_valid[base + w]) begin
                     slot_valid[base + w] = 1'b1;
                     slot_trade[base + w] = cur_trade;
                     slot_order[base + w] = cur_order;
                     ans.status = ST_INSERTED;
                  end
               end
               if (ans.status == ST_FULL && overflow_total != 32'hffffffff)
                  overflow_total++;
            end
         end
      end else if (op == OP_CLEAR) begin
         if (id_len_ok(cur_order_len)) begin
            for (int e = 0; e < ENTRY_COUNT; e++) begin
               if (slot_valid[e] && same_key(slot_order[e], cur_order)) begin
                  slot_valid[e] = 1'b0;
                  if (ans.cleared != 13'h1fff) ans.cleared++;
               end
            end
            ans.status = ST_CLEARED;
         end
      end
      ans.overflows = overflow_total;
      pending_answers.push_back(ans);
      restart_key();
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= hold_rsp ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 37);
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, -1);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_cleared_count !== want.cleared)
               report_mismatch("cleared_count", rsp_cleared_count, want.cleared);
            if (rsp_overflow_total !== want.overflows)
               report_mismatch("overflow_total", rsp_overflow_total, want.overflows);
         end
      end
   end

   task automatic send_item(op_type op, logic part, logic has_byte, logic [7:0] kb,
                            logic last);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_part <= part;
      req_has_byte <= has_byte;
      req_key_byte <= kb;
      req_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(op, part, has_byte, kb, last);
      items_sent++;
   endtask

   // Sends a full command; an empty order id ends with a byteless request.
   task automatic send_command(op_type op, key_q trade, key_q order);
      foreach (trade[i]) send_item(op, PART_TRADE, 1'b1, trade[i], 1'b0);
      foreach (order[i]) send_item(op, PART_ORDER, 1'b1, order[i], i == order.size() - 1);
      if (order.size() == 0) send_item(op, PART_ORDER, 1'b0, 8'($urandom), 1'b1);
   endtask

   function automatic key_q random_key(int len);
      key_q k;
      repeat (len) k.push_back(8'($urandom));
      return k;
   endfunction

   function automatic key_q filled_key(int len, logic [7:0] value);
      key_q k;
      repeat (len) k.push_back(value);
      return k;
   endfunction

   task automatic test_basic_ops();
      key_q t, o;
      t = '{8'h00, 8'hff};
      o = '{8'hff, 8'h00};
      send_command(OP_INSERT, t, o);
      send_command(OP_QUERY, t, o);
      send_command(OP_INSERT, t, o);
      send_command(OP_QUERY, '{8'h01}, o);
      // Earlier requests carry other ops and a byteless filler; the last one decides.
      send_item(OP_CLEAR, PART_TRADE, 1'b1, 8'h00, 1'b0);
      send_item(OP_UNUSED, PART_TRADE, 1'b0, 8'h5a, 1'b0);
      send_item(OP_INSERT, PART_TRADE, 1'b1, 8'hff, 1'b0);
      send_item(OP_CLEAR, PART_ORDER, 1'b1, 8'hff, 1'b0);
      send_item(OP_QUERY, PART_ORDER, 1'b1, 8'h00, 1'b1);
   endtask

   task automatic test_key_limits();
      key_q longest, too_long;
      longest = random_key(MAX_ID_BYTES);
      too_long = random_key(MAX_ID_BYTES + 1);
      send_command(OP_INSERT, longest, longest);
      send_command(OP_QUERY, longest, longest);
      send_command(OP_INSERT, too_long, '{8'h01});
      send_command(OP_QUERY, '{8'h01}, too_long);
      send_command(OP_INSERT, '{}, '{8'h01});
      send_command(OP_INSERT, '{8'h01}, '{});
      send_command(OP_UNUSED, '{8'h01}, '{8'h01});
      // A trade byte after the order id has started spoils the trade id.
      send_item(OP_INSERT, PART_TRADE, 1'b1, 8'h11, 1'b0);
      send_item(OP_INSERT, PART_ORDER, 1'b1, 8'h22, 1'b0);
      send_item(OP_INSERT, PART_TRADE, 1'b1, 8'h33, 1'b1);
   endtask

   task automatic test_bucket_full();
      for (int i = 0; i < 5; i++) send_command(OP_INSERT, pool_trade[i], pool_order[i]);
      send_command(OP_QUERY, pool_trade[4], pool_order[4]);
      send_command(OP_INSERT, pool_trade[4], pool_order[4]);
      send_command(OP_INSERT, pool_trade[2], pool_order[2]);
   endtask

   task automatic test_clear_order();
      send_command(OP_CLEAR, '{8'h77, 8'h78}, pool_order[0]);
      send_command(OP_CLEAR, '{}, pool_order[0]);
      send_command(OP_CLEAR, '{}, '{});
      send_command(OP_CLEAR, '{}, random_key(MAX_ID_BYTES + 1));
      send_command(OP_QUERY, pool_trade[1], pool_order[1]);
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      for (int i = 0; i < 30; i++)
         send_command($urandom_range(0, 1) ? OP_INSERT : OP_QUERY,
                      pool_trade[$urandom_range(0, 39)], pool_order[$urandom_range(0, 39)]);
   endtask

   task automatic test_random_traffic();
      int pick, r, start;
      op_type op;
      start = items_sent;
      no_idle = 1'b1;
      while (items_sent - start < 150) begin
         if (items_sent - start > 90) no_idle = 1'b0;
         r = $urandom_range(0, 99);
         op = r < 45 ? OP_INSERT : r < 85 ? OP_QUERY : r < 88 ? OP_CLEAR : OP_UNUSED;
         pick = $urandom_range(0, 39);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_command(op, pool_trade[pick], pool_order[pick]);
         end else if (r < 88) begin
            send_command(op, random_key($urandom_range(1, 6)), pool_order[pick]);
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(op_type'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                         8'($urandom), 1'b0);
            send_item(op, 1'($urandom), 1'($urandom), 8'($urandom), 1'b1);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int found;
      key_q probe, base_order;
      restart_key();
      overflow_total = '0;
      base_order = '{8'h4f};
      found = 0;
      for (int i = 0; i < 65536 && found < 5; i++) begin
         probe = '{8'(i >> 8), 8'(i)};
         if (bucket_of(probe, base_order) == bucket_of('{8'h00, 8'h00}, base_order)) begin
            pool_trade[found] = probe;
            pool_order[found] = base_order;
            found++;
         end
      end
      for (int i = 5; i < 40; i++) begin
         pool_trade[i] = random_key($urandom_range(1, 5));
         pool_order[i] = filled_key($urandom_range(1, 3), 8'($urandom_range(0, 5)));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_key_limits();
      test_bucket_full();
      test_clear_order();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
